>>> hw/rtl/fgt_pkg.sv
`default_nettype none

package fgt_pkg;

    // Field widths of a request and a response, the group count setting and the group counters
    localparam int unsigned GRP_W   = 6;
    localparam int unsigned PORT_W  = 3;
    localparam int unsigned OWNER_W = 8;
    localparam int unsigned CFG_W   = 7;
    localparam int unsigned CNT_W   = 32;

    // Table sizes follow the field widths
    localparam int unsigned GROUPS    = 2 ** GRP_W;
    localparam int unsigned KEY_W     = PORT_W + OWNER_W + GRP_W;
    localparam int unsigned KEY_SLOTS = 2 ** KEY_W;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(GROUPS);

    // Request kinds
    localparam logic KIND_XLATE   = 1'b0;
    localparam logic KIND_REVERSE = 1'b1;

    // Response status codes
    localparam logic STAT_OK  = 1'b0;
    localparam logic STAT_ERR = 1'b1;

    // Access to the key store
    typedef struct packed {
        logic             rd_en;
        logic             wr_en;
        logic [KEY_W-1:0] addr;
        logic [GRP_W-1:0] wdata;
    } t_key_cmd;

    // Access to the group table
    typedef struct packed {
        logic             rd_en;
        logic [GRP_W-1:0] rd_addr;
        logic             alloc;
        logic             bump;
        logic [GRP_W-1:0] wr_addr;
        logic [GRP_W-1:0] origin;
    } t_tbl_cmd;

    // Group table read data and free search result
    typedef struct packed {
        logic             used;
        logic [GRP_W-1:0] origin;
        logic             free_found;
        logic [GRP_W-1:0] free_idx;
    } t_tbl_rsp;

endpackage

`default_nettype wire

>>> hw/rtl/fgt_if.sv
`default_nettype none

interface fgt_req_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [fgt_pkg::OWNER_W-1:0] owner;
    logic [fgt_pkg::PORT_W-1:0]  port;
    logic [fgt_pkg::GRP_W-1:0]   group;

    modport source (output valid, kind, owner, port, group, input ready);
    modport sink   (input valid, kind, owner, port, group, output ready);
endinterface

interface fgt_rsp_if;
    logic                      valid;
    logic                      ready;
    logic                      status;
    logic [fgt_pkg::GRP_W-1:0] group_result;

    modport source (output valid, status, group_result, input ready);
    modport sink   (input valid, status, group_result, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/fgt_key_store.sv
`default_nettype none

module fgt_key_store (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire fgt_pkg::t_key_cmd     i_cmd,
    output logic [fgt_pkg::GRP_W-1:0]  o_rd_data,
    output logic                       o_ready
);

    logic [fgt_pkg::GRP_W-1:0] mem [fgt_pkg::KEY_SLOTS];

    logic                      r_clr_busy;
    logic [fgt_pkg::KEY_W-1:0] r_clr_addr;
    logic [fgt_pkg::GRP_W-1:0] r_rd_data;

    logic                      wr_en;
    logic [fgt_pkg::KEY_W-1:0] wr_addr;
    logic [fgt_pkg::GRP_W-1:0] wr_data;

    // Sweep every slot to unmapped after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (&r_clr_addr) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Clearing owns the write port while it runs
    assign wr_en   = r_clr_busy | i_cmd.wr_en;
    assign wr_addr = r_clr_busy ? r_clr_addr : i_cmd.addr;
    assign wr_data = r_clr_busy ? '0 : i_cmd.wdata;

    // Memory with separate write and read addresses, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[i_cmd.addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_ready   = ~r_clr_busy;

endmodule

`default_nettype wire

>>> hw/rtl/fgt_group_table.sv
`default_nettype none

module fgt_group_table (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire fgt_pkg::t_tbl_cmd     i_cmd,
    input  wire [fgt_pkg::CFG_W-1:0]   i_limit,
    output fgt_pkg::t_tbl_rsp          o_rsp
);

    logic [fgt_pkg::CNT_W-1:0] cnt_mem    [fgt_pkg::GROUPS];
    logic [fgt_pkg::GRP_W-1:0] origin_mem [fgt_pkg::GROUPS];

    logic [fgt_pkg::GROUPS-1:0] r_used;
    logic [fgt_pkg::CNT_W-1:0]  r_cnt_rd;
    logic [fgt_pkg::GRP_W-1:0]  r_origin_rd;
    logic                       r_used_rd;

    logic [fgt_pkg::CNT_W-1:0]  cnt_wdata;
    logic [fgt_pkg::GROUPS-1:0] cand;
    logic [fgt_pkg::GROUPS-1:0] lowest;
    logic [fgt_pkg::GRP_W-1:0]  free_idx;

    // Mark groups in use; a group is never released
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_cmd.alloc) begin
            r_used[i_cmd.wr_addr] <= 1'b1;
        end
    end

    // New group starts at one, a bump saturates
    assign cnt_wdata = i_cmd.alloc ? fgt_pkg::CNT_W'(1) :
                       ((&r_cnt_rd) ? r_cnt_rd : r_cnt_rd + 1'b1);

    // Count and origin memories, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.alloc || i_cmd.bump) begin
            cnt_mem[i_cmd.wr_addr] <= cnt_wdata;
        end
        if (i_cmd.alloc) begin
            origin_mem[i_cmd.wr_addr] <= i_cmd.origin;
        end
        if (i_cmd.rd_en) begin
            r_cnt_rd    <= cnt_mem[i_cmd.rd_addr];
            r_origin_rd <= origin_mem[i_cmd.rd_addr];
        end
    end

    // Track the in-use flag of the entry just read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used_rd <= 1'b0;
        end else if (i_cmd.rd_en) begin
            r_used_rd <= r_used[i_cmd.rd_addr];
        end
    end

    // Free groups from one up to one below the limit
    always_comb begin
        for (int i = 0; i < fgt_pkg::GROUPS; i++) begin
            cand[i] = ~r_used[i] && (i != 0) && (fgt_pkg::CFG_W'(i) < i_limit);
        end
    end

    // Isolate the lowest free group and encode it
    assign lowest = cand & (~cand + 1'b1);

    always_comb begin
        free_idx = '0;
        for (int i = 0; i < fgt_pkg::GROUPS; i++) begin
            if (lowest[i]) begin
                free_idx = free_idx | fgt_pkg::GRP_W'(i);
            end
        end
    end

    assign o_rsp.used       = r_used_rd;
    assign o_rsp.origin     = r_origin_rd;
    assign o_rsp.free_found = |cand;
    assign o_rsp.free_idx   = free_idx;

endmodule

`default_nettype wire

>>> hw/rtl/flow_group_translator.sv
// Translates (port, owner, group) keys to hardware group numbers.
// i_req carries one request per valid/ready handshake: kind 0 translates an
// original group, kind 1 looks up the original group of a hardware group.
// o_rsp returns exactly one response per request, in order, with status and
// group_result. i_cfg_we / i_cfg_wdata set the number of usable groups;
// write it only while no request is in flight.
// One request is worked on at a time. A taken request goes through S_LOOK,
// then S_BUMP when a mapped key bumps its count (the extra read-modify-write
// of the count memory), then S_DONE, which loads the response register. The
// next request is taken only in S_IDLE, after the response is loaded.
// The response register holds while o_rsp.ready is low; a finished request
// waits in its last step until that register is free.
// After reset the key store is swept to unmapped, one slot a cycle, through all
// 131072 slots; i_req.ready stays low meanwhile, configuration writes are
// taken. Group counts and origins are not cleared; in-use flags clear at once.
`default_nettype none

module flow_group_translator (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    fgt_req_if.sink                    i_req,
    fgt_rsp_if.source                  o_rsp,
    input  wire                        i_cfg_we,
    input  wire [fgt_pkg::CFG_W-1:0]   i_cfg_wdata
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_BUMP = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]                  r_state, n_state;
    logic [fgt_pkg::CFG_W-1:0]   r_groups_in_use;
    logic                        r_kind, n_kind;
    logic [fgt_pkg::KEY_W-1:0]   r_slot, n_slot;
    logic [fgt_pkg::GRP_W-1:0]   r_grp, n_grp;
    logic [fgt_pkg::GRP_W-1:0]   r_hw, n_hw;
    logic                        r_res_status, n_res_status;
    logic [fgt_pkg::GRP_W-1:0]   r_res_group, n_res_group;
    logic                        r_out_valid, n_out_valid;
    logic                        r_out_status, n_out_status;
    logic [fgt_pkg::GRP_W-1:0]   r_out_group, n_out_group;

    fgt_pkg::t_key_cmd           key_cmd;
    fgt_pkg::t_tbl_cmd           tbl_cmd;
    fgt_pkg::t_tbl_rsp           tbl_rsp;
    logic [fgt_pkg::GRP_W-1:0]   key_rd;
    logic                        key_ready;
    logic [fgt_pkg::CFG_W-1:0]   eff_limit;
    logic                        grp_bad;
    logic                        req_take;
    logic                        out_free;

    fgt_key_store u_key_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (key_cmd),
        .o_rd_data (key_rd),
        .o_ready   (key_ready)
    );

    fgt_group_table u_group_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (tbl_cmd),
        .i_limit (eff_limit),
        .o_rsp   (tbl_rsp)
    );

    // Hold the group count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_groups_in_use <= fgt_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            r_groups_in_use <= i_cfg_wdata;
        end
    end

    // Clamp the count to the table size
    assign eff_limit = (r_groups_in_use > fgt_pkg::CFG_W'(fgt_pkg::GROUPS)) ?
                       fgt_pkg::CFG_W'(fgt_pkg::GROUPS) : r_groups_in_use;
    assign grp_bad   = ({1'b0, r_grp} >= eff_limit);

    assign i_req.ready = (r_state == S_IDLE) && key_ready;
    assign req_take    = i_req.valid && i_req.ready;
    assign out_free    = ~r_out_valid | o_rsp.ready;

    // Sequence one request through the memories
    always_comb begin
        n_state      = r_state;
        n_kind       = r_kind;
        n_slot       = r_slot;
        n_grp        = r_grp;
        n_hw         = r_hw;
        n_res_status = r_res_status;
        n_res_group  = r_res_group;
        n_out_valid  = r_out_valid & ~o_rsp.ready;
        n_out_status = r_out_status;
        n_out_group  = r_out_group;
        key_cmd      = '0;
        tbl_cmd      = '0;

        case (r_state)
            S_IDLE: begin
                if (req_take) begin
                    n_kind          = i_req.kind;
                    n_grp           = i_req.group;
                    n_slot          = {i_req.port, i_req.owner, i_req.group};
                    key_cmd.rd_en   = 1'b1;
                    key_cmd.addr    = {i_req.port, i_req.owner, i_req.group};
                    tbl_cmd.rd_en   = 1'b1;
                    tbl_cmd.rd_addr = i_req.group;
                    n_state         = S_LOOK;
                end
            end
            S_LOOK: begin
                n_res_status = fgt_pkg::STAT_OK;
                n_res_group  = '0;
                n_state      = S_DONE;
                if (grp_bad) begin
                    n_res_status = fgt_pkg::STAT_ERR;
                end else if (r_grp == '0) begin
                    n_res_group = '0;
                end else if (r_kind == fgt_pkg::KIND_REVERSE) begin
                    if (tbl_rsp.used) begin
                        n_res_group = tbl_rsp.origin;
                    end else begin
                        n_res_status = fgt_pkg::STAT_ERR;
                    end
                end else if (key_rd != '0) begin
                    // Mapped key: read its count for the bump
                    tbl_cmd.rd_en   = 1'b1;
                    tbl_cmd.rd_addr = key_rd;
                    n_hw            = key_rd;
                    n_res_group     = key_rd;
                    n_state         = S_BUMP;
                end else if (tbl_rsp.free_found) begin
                    // Unmapped key: claim the lowest free group
                    tbl_cmd.alloc   = 1'b1;
                    tbl_cmd.wr_addr = tbl_rsp.free_idx;
                    tbl_cmd.origin  = r_grp;
                    key_cmd.wr_en   = 1'b1;
                    key_cmd.addr    = r_slot;
                    key_cmd.wdata   = tbl_rsp.free_idx;
                    n_res_group     = tbl_rsp.free_idx;
                end else begin
                    n_res_status = fgt_pkg::STAT_ERR;
                end
            end
            S_BUMP: begin
                tbl_cmd.bump    = 1'b1;
                tbl_cmd.wr_addr = r_hw;
                n_state         = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_group  = r_res_group;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Request and response payload
    always_ff @(posedge i_clk) begin
        r_kind       <= n_kind;
        r_slot       <= n_slot;
        r_grp        <= n_grp;
        r_hw         <= n_hw;
        r_res_status <= n_res_status;
        r_res_group  <= n_res_group;
        r_out_status <= n_out_status;
        r_out_group  <= n_out_group;
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.group_result = r_out_group;

`ifndef SYNTHESIS
    // An error response never carries a group
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && (o_rsp.status == fgt_pkg::STAT_ERR) |-> (o_rsp.group_result == '0))
        else $error("error response with nonzero group");

    // A claimed group lies inside the usable range and is never group zero
    a_alloc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tbl_cmd.alloc |-> (tbl_cmd.wr_addr != '0) && ({1'b0, tbl_cmd.wr_addr} < eff_limit))
        else $error("group claimed outside usable range");

    // A count bump always follows the lookup of a mapped key
    a_bump_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BUMP) |-> ($past(r_state) == S_LOOK) && (r_hw != '0))
        else $error("count bump without a mapped lookup");

    // No request is taken while the key store is still clearing
    a_no_take_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !key_ready |=> (r_state == S_IDLE))
        else $error("request taken during key store clear");
`endif

endmodule

`default_nettype wire
